### src/bpsm_pkg.sv
`default_nettype none
package bpsm_pkg;

   localparam int MAX_PARTICLES = 4096;
   localparam int ADDR_W        = $clog2(MAX_PARTICLES);
   localparam int CNT_W         = $clog2(MAX_PARTICLES + 1);
   localparam int COORD_W       = 32;
   localparam int SUM_W         = COORD_W + ADDR_W;
   localparam int WIDE_W        = 256;
   localparam int VAL_W         = 64;
   localparam int NUM_MOM       = 12;
   localparam int NUM_RES       = 18;
   localparam int IDX_W         = 5;
   localparam int CSR_ADDR_W    = 5;

   // register indexes on the csr port
   localparam logic [2:0] REG_BOX_MIN_FIRST  = 3'd0;
   localparam logic [2:0] REG_BOX_MAX_FIRST  = 3'd1;
   localparam logic [2:0] REG_BOX_MIN_SECOND = 3'd2;
   localparam logic [2:0] REG_BOX_MAX_SECOND = 3'd3;
   localparam logic [2:0] REG_MOMENTS_EN     = 3'd4;
   localparam logic [2:0] REG_DERIVED_EN     = 3'd5;
   localparam logic [2:0] REG_BOX_LABEL      = 3'd6;

   // result slots
   localparam logic [IDX_W-1:0] RES_LABEL = 5'd0;
   localparam logic [IDX_W-1:0] RES_COUNT = 5'd1;
   localparam logic [IDX_W-1:0] RES_EMIT  = 5'd2;
   localparam logic [IDX_W-1:0] RES_HALO  = 5'd3;
   localparam logic [IDX_W-1:0] RES_MEAN  = 5'd4;
   localparam logic [IDX_W-1:0] RES_MOM   = 5'd6;
   localparam logic [IDX_W-1:0] RES_LAST  = 5'd17;

   // stored power products
   localparam logic [2:0] POW_X2  = 3'd0;
   localparam logic [2:0] POW_X3  = 3'd1;
   localparam logic [2:0] POW_Y2  = 3'd2;
   localparam logic [2:0] POW_Y3  = 3'd3;
   localparam logic [2:0] POW_X2Y = 3'd4;
   localparam int         NUM_POW = 5;

   typedef enum logic [1:0] {
      ALU_MUL  = 2'd0,
      ALU_DIV  = 2'd1,
      ALU_SQRT = 2'd2
   } alu_op_type;

   typedef struct packed {
      logic                     start;
      alu_op_type               op;
      logic signed [WIDE_W-1:0] a;
      logic signed [WIDE_W-1:0] b;
   } alu_cmd_type;

   typedef struct packed {
      logic                     done;
      logic signed [WIDE_W-1:0] res;
   } alu_rsp_type;

   typedef struct packed {
      logic       a_dev;
      logic       a_y;
      logic [2:0] a_pow;
      logic       b_y;
      logic       w_pow;
      logic [2:0] d_pow;
      logic [3:0] sidx;
   } mul_step_type;

   // per-particle product schedule: every product is a stored term times x or y
   function automatic mul_step_type mul_step(input logic [3:0] s);
      mul_step_type m;
      m = '0;
      case (s)
         4'd0:  begin m.a_dev = 1'b1; m.w_pow = 1'b1; m.d_pow = POW_X2; m.sidx = 4'd0; end
         4'd1:  begin m.a_pow = POW_X2; m.w_pow = 1'b1; m.d_pow = POW_X3; m.sidx = 4'd3; end
         4'd2:  begin m.a_pow = POW_X3; m.sidx = 4'd7; end
         4'd3:  begin m.a_dev = 1'b1; m.a_y = 1'b1; m.b_y = 1'b1; m.w_pow = 1'b1;
                      m.d_pow = POW_Y2; m.sidx = 4'd2; end
         4'd4:  begin m.a_pow = POW_Y2; m.b_y = 1'b1; m.w_pow = 1'b1; m.d_pow = POW_Y3;
                      m.sidx = 4'd6; end
         4'd5:  begin m.a_pow = POW_Y3; m.b_y = 1'b1; m.sidx = 4'd11; end
         4'd6:  begin m.a_dev = 1'b1; m.b_y = 1'b1; m.sidx = 4'd1; end
         4'd7:  begin m.a_pow = POW_X2; m.b_y = 1'b1; m.w_pow = 1'b1; m.d_pow = POW_X2Y;
                      m.sidx = 4'd4; end
         4'd8:  begin m.a_pow = POW_X2Y; m.b_y = 1'b1; m.sidx = 4'd9; end
         4'd9:  begin m.a_pow = POW_Y2; m.sidx = 4'd5; end
         4'd10: begin m.a_pow = POW_X3; m.b_y = 1'b1; m.sidx = 4'd8; end
         4'd11: begin m.a_pow = POW_Y3; m.sidx = 4'd10; end
         default: m = '0;
      endcase
      return m;
   endfunction

   // order minus one, in 32-bit words, of moment k
   function automatic logic [1:0] mom_shift(input logic [3:0] k);
      logic [1:0] r;
      case (k)
         4'd0, 4'd1, 4'd2:                 r = 2'd1;
         4'd3, 4'd4, 4'd5, 4'd6:           r = 2'd2;
         default:                          r = 2'd3;
      endcase
      return r;
   endfunction

   function automatic logic signed [VAL_W-1:0] sat64(input logic signed [WIDE_W-1:0] v);
      logic signed [VAL_W-1:0] r;
      if ((v[WIDE_W-1:VAL_W-1] == '0) || (v[WIDE_W-1:VAL_W-1] == '1)) begin
         r = v[VAL_W-1:0];
      end else if (v[WIDE_W-1]) begin
         r = {1'b1, {(VAL_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(VAL_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

### src/bpsm_req_if.sv
`default_nettype none
interface bpsm_req_if;
   logic        valid;
   logic        ready;
   logic signed [31:0] coord_first;
   logic signed [31:0] coord_second;
   logic        last_particle;

   modport source (output valid, coord_first, coord_second, last_particle, input ready);
   modport sink   (input valid, coord_first, coord_second, last_particle, output ready);
endinterface
`default_nettype wire

### src/bpsm_rsp_if.sv
`default_nettype none
interface bpsm_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  quantity_index;
   logic signed [63:0] quantity_value;
   logic        last_quantity;

   modport source (output valid, quantity_index, quantity_value, last_quantity, input ready);
   modport sink   (input valid, quantity_index, quantity_value, last_quantity, output ready);
endinterface
`default_nettype wire

### src/box_phase_space_moments_core.sv
`default_nettype none
// Phase-space moments of the particles that fall inside a box.
//
// req: one coordinate pair per item (Q16.16), last_particle closes a set.
//   While loading, req.ready is high and an item is taken every cycle. A pair
//   inside the box (inclusive bounds) is stored, counted and summed, up to
//   MAX_PARTICLES pairs per set.
// After the closing item req.ready drops while the shared unit works:
//   2 rounding divides for the means, then with moments on, per kept pair
//   12 shift-add multiplies, then 12 rounding divides for the moments, and
//   with derived quantities on 3 multiplies, one 64-step square root and
//   one more divide. An empty box goes straight to the results.
// rsp: 18 items, index 0..17, last_quantity on index 17. They leave one per
//   cycle through an output register and hold while rsp.ready is low.
//   Loading resumes as the last one enters the output register.
// csr: APB-style, registers at 4*i; the user writes them only while idle, unchecked by the block.
// Reset (synchronous) clears registers, count and sums; the particle store
//   is not cleared, only entries below the count are read.
module box_phase_space_moments_core import bpsm_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   bpsm_req_if.sink                   req,
   bpsm_rsp_if.source                 rsp,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]           pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);

   typedef enum logic [8:0] {
      ST_LOAD   = 9'b000000001,
      ST_INIT   = 9'b000000010,
      ST_MEAN   = 9'b000000100,
      ST_RDADDR = 9'b000001000,
      ST_DEV    = 9'b000010000,
      ST_MUL    = 9'b000100000,
      ST_MOMDIV = 9'b001000000,
      ST_DER    = 9'b010000000,
      ST_EMIT   = 9'b100000000
   } state_type;

   // config registers
   logic signed [31:0] box_min_first_ff, box_max_first_ff;
   logic signed [31:0] box_min_second_ff, box_max_second_ff;
   logic               moments_en_ff, derived_en_ff;
   logic [15:0]        box_label_ff;

   // set state
   logic [63:0]              mem [MAX_PARTICLES];
   logic [63:0]              rd_data_ff;
   logic [CNT_W-1:0]         count_ff;
   logic signed [SUM_W-1:0]  csum_ff [2];
   logic signed [WIDE_W-1:0] msum_ff [NUM_MOM];
   logic signed [WIDE_W-1:0] pow_ff [NUM_POW];
   logic signed [WIDE_W-1:0] tmp_ff;
   logic signed [VAL_W-1:0]  val_ff [NUM_RES];
   logic signed [63:0]       dx_ff, dy_ff;

   // sequencer
   state_type          state_ff;
   logic [3:0]         step_ff;
   logic [CNT_W-1:0]   p_ff;
   logic               pend_ff;
   logic [IDX_W-1:0]   idx_ff;

   // output register
   logic                     rsp_valid_ff;
   logic [IDX_W-1:0]         rsp_idx_ff;
   logic signed [VAL_W-1:0]  rsp_val_ff;
   logic                     rsp_last_ff;

   alu_cmd_type  alu_cmd;
   alu_rsp_type  alu_rsp;
   mul_step_type ms;

   logic               csr_wr;
   logic [2:0]         csr_idx;
   logic               accept;
   logic               in_box;
   logic               keep;
   logic               skip;
   logic               out_free;
   logic               emit_go;
   logic signed [63:0] dx_in, dy_in;
   logic signed [WIDE_W-1:0] sum_sel;

   bpsm_alu u_alu (
      .clock (clock),
      .reset (reset),
      .cmd   (alu_cmd),
      .rsp   (alu_rsp)
   );

   // ---------------- csr port ----------------
   assign pready  = 1'b1;
   assign csr_idx = paddr[4:2];
   assign csr_wr  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_min_first_ff  <= '0;
         box_max_first_ff  <= '0;
         box_min_second_ff <= '0;
         box_max_second_ff <= '0;
         moments_en_ff     <= 1'b0;
         derived_en_ff     <= 1'b0;
         box_label_ff      <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_BOX_MIN_FIRST:  box_min_first_ff  <= pwdata;
            REG_BOX_MAX_FIRST:  box_max_first_ff  <= pwdata;
            REG_BOX_MIN_SECOND: box_min_second_ff <= pwdata;
            REG_BOX_MAX_SECOND: box_max_second_ff <= pwdata;
            REG_MOMENTS_EN:     moments_en_ff     <= pwdata[0];
            REG_DERIVED_EN:     derived_en_ff     <= pwdata[0];
            REG_BOX_LABEL:      box_label_ff      <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_BOX_MIN_FIRST:  prdata = box_min_first_ff;
         REG_BOX_MAX_FIRST:  prdata = box_max_first_ff;
         REG_BOX_MIN_SECOND: prdata = box_min_second_ff;
         REG_BOX_MAX_SECOND: prdata = box_max_second_ff;
         REG_MOMENTS_EN:     prdata = {31'd0, moments_en_ff};
         REG_DERIVED_EN:     prdata = {31'd0, derived_en_ff};
         REG_BOX_LABEL:      prdata = {16'd0, box_label_ff};
         default:            prdata = '0;
      endcase
   end

   // ---------------- load path ----------------
   assign req.ready = (state_ff == ST_LOAD);
   assign accept    = req.valid && req.ready;
   assign in_box    = (req.coord_first  >= box_min_first_ff)  &&
                      (req.coord_first  <= box_max_first_ff)  &&
                      (req.coord_second >= box_min_second_ff) &&
                      (req.coord_second <= box_max_second_ff);
   assign keep      = accept && in_box && (count_ff < CNT_W'(MAX_PARTICLES));

   // store: pair written at the count, read back at the particle pointer
   always_ff @(posedge clock) begin
      if (keep) mem[count_ff[ADDR_W-1:0]] <= {req.coord_second, req.coord_first};
      rd_data_ff <= mem[p_ff[ADDR_W-1:0]];
   end

   // deviation in Q32.32 from the stored pair and the means
   assign dx_in = {{16{rd_data_ff[31]}}, rd_data_ff[31:0], 16'd0} - val_ff[RES_MEAN];
   assign dy_in = {{16{rd_data_ff[63]}}, rd_data_ff[63:32], 16'd0} - val_ff[RES_MEAN + 5'd1];

   // ---------------- shared unit command ----------------
   assign ms      = mul_step(step_ff);
   assign sum_sel = WIDE_W'(csum_ff[step_ff[0]]);

   always_comb begin
      alu_cmd.op = ALU_MUL;
      alu_cmd.a  = '0;
      alu_cmd.b  = '0;
      skip       = 1'b0;
      case (state_ff)
         ST_MEAN: begin
            alu_cmd.op = ALU_DIV;
            alu_cmd.a  = sum_sel <<< 16;
            alu_cmd.b  = {{(WIDE_W-CNT_W){1'b0}}, count_ff};
         end
         ST_MUL: begin
            alu_cmd.op = ALU_MUL;
            if (ms.a_dev) begin
               alu_cmd.a = WIDE_W'(ms.a_y ? dy_ff : dx_ff);
            end else begin
               alu_cmd.a = pow_ff[ms.a_pow];
            end
            alu_cmd.b = WIDE_W'(ms.b_y ? dy_ff : dx_ff);
         end
         ST_MOMDIV: begin
            alu_cmd.op = ALU_DIV;
            alu_cmd.a  = msum_ff[step_ff];
            alu_cmd.b  = {{(WIDE_W-CNT_W){1'b0}}, count_ff} << (32 * mom_shift(step_ff));
         end
         ST_DER: begin
            case (step_ff)
               4'd0: begin
                  alu_cmd.a = WIDE_W'(val_ff[RES_MOM]);
                  alu_cmd.b = WIDE_W'(val_ff[RES_MOM + 5'd2]);
               end
               4'd1: begin
                  alu_cmd.a = WIDE_W'(val_ff[RES_MOM + 5'd1]);
                  alu_cmd.b = WIDE_W'(val_ff[RES_MOM + 5'd1]);
               end
               4'd2: begin
                  alu_cmd.op = ALU_SQRT;
                  alu_cmd.a  = tmp_ff;
                  skip       = tmp_ff[WIDE_W-1];
               end
               4'd3: begin
                  alu_cmd.a = WIDE_W'(val_ff[RES_MOM]);
                  alu_cmd.b = WIDE_W'(val_ff[RES_MOM]);
               end
               default: begin
                  alu_cmd.op = ALU_DIV;
                  alu_cmd.a  = WIDE_W'(val_ff[RES_MOM + 5'd7]) <<< 64;
                  alu_cmd.b  = tmp_ff;
                  skip       = (tmp_ff == '0);
               end
            endcase
         end
         default: ;
      endcase
      alu_cmd.start = !pend_ff && !skip &&
                      ((state_ff == ST_MEAN) || (state_ff == ST_MUL) ||
                       (state_ff == ST_MOMDIV) || (state_ff == ST_DER));
   end

   // ---------------- sequencer ----------------
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign emit_go  = (state_ff == ST_EMIT) && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         step_ff      <= '0;
         p_ff         <= '0;
         pend_ff      <= 1'b0;
         idx_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 2; i++) csum_ff[i] <= '0;
         for (int i = 0; i < NUM_MOM; i++) msum_ff[i] <= '0;
      end else begin
         if (alu_rsp.done) begin
            pend_ff <= 1'b0;
         end else if (alu_cmd.start) begin
            pend_ff <= 1'b1;
         end

         if (emit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_LOAD: begin
               if (keep) begin
                  count_ff   <= count_ff + 1'b1;
                  csum_ff[0] <= csum_ff[0] + SUM_W'(req.coord_first);
                  csum_ff[1] <= csum_ff[1] + SUM_W'(req.coord_second);
               end
               if (accept && req.last_particle) state_ff <= ST_INIT;
            end
            ST_INIT: begin
               for (int i = int'(RES_EMIT); i < NUM_RES; i++) val_ff[i] <= '0;
               val_ff[RES_LABEL] <= VAL_W'(box_label_ff);
               val_ff[RES_COUNT] <= VAL_W'(count_ff);
               step_ff <= '0;
               p_ff    <= '0;
               idx_ff  <= '0;
               // empty box: every quantity but the label stays zero
               state_ff <= (count_ff == '0) ? ST_EMIT : ST_MEAN;
            end
            ST_MEAN: begin
               if (alu_rsp.done) begin
                  val_ff[RES_MEAN + IDX_W'(step_ff[0])] <= sat64(alu_rsp.res);
                  if (step_ff[0]) begin
                     step_ff  <= '0;
                     state_ff <= moments_en_ff ? ST_RDADDR : ST_EMIT;
                  end else begin
                     step_ff <= 4'd1;
                  end
               end
            end
            ST_RDADDR: state_ff <= ST_DEV;
            ST_DEV: begin
               dx_ff    <= dx_in;
               dy_ff    <= dy_in;
               step_ff  <= '0;
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               if (alu_rsp.done) begin
                  msum_ff[ms.sidx] <= msum_ff[ms.sidx] + alu_rsp.res;
                  if (ms.w_pow) pow_ff[ms.d_pow] <= alu_rsp.res;
                  if (step_ff == 4'(NUM_MOM - 1)) begin
                     step_ff <= '0;
                     if (CNT_W'(p_ff + 1'b1) == count_ff) begin
                        state_ff <= ST_MOMDIV;
                     end else begin
                        p_ff     <= p_ff + 1'b1;
                        state_ff <= ST_RDADDR;
                     end
                  end else begin
                     step_ff <= step_ff + 4'd1;
                  end
               end
            end
            ST_MOMDIV: begin
               if (alu_rsp.done) begin
                  val_ff[RES_MOM + IDX_W'(step_ff)] <= sat64(alu_rsp.res);
                  if (step_ff == 4'(NUM_MOM - 1)) begin
                     step_ff  <= '0;
                     state_ff <= derived_en_ff ? ST_DER : ST_EMIT;
                  end else begin
                     step_ff <= step_ff + 4'd1;
                  end
               end
            end
            ST_DER: begin
               // 0: m_x2*m_xp2, 1: minus m_xxp^2, 2: sqrt, 3: m_x2^2, 4: halo divide
               if (skip) begin
                  if (step_ff == 4'd4) begin
                     state_ff <= ST_EMIT;
                  end else begin
                     step_ff <= step_ff + 4'd1;
                  end
               end else if (alu_rsp.done) begin
                  case (step_ff)
                     4'd0:    tmp_ff <= alu_rsp.res;
                     4'd1:    tmp_ff <= tmp_ff - alu_rsp.res;
                     4'd2:    val_ff[RES_EMIT] <= sat64(alu_rsp.res);
                     4'd3:    tmp_ff <= alu_rsp.res;
                     default: val_ff[RES_HALO] <=
                                 sat64(alu_rsp.res - (WIDE_W'(1) << 33));
                  endcase
                  if (step_ff == 4'd4) begin
                     state_ff <= ST_EMIT;
                  end else begin
                     step_ff <= step_ff + 4'd1;
                  end
               end
            end
            ST_EMIT: begin
               if (emit_go) begin
                  rsp_idx_ff   <= idx_ff;
                  rsp_val_ff   <= val_ff[idx_ff];
                  rsp_last_ff  <= (idx_ff == RES_LAST);
                  if (idx_ff == RES_LAST) begin
                     // start a new, empty set
                     count_ff <= '0;
                     for (int i = 0; i < 2; i++) csum_ff[i] <= '0;
                     for (int i = 0; i < NUM_MOM; i++) msum_ff[i] <= '0;
                     state_ff <= ST_LOAD;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                  end
               end
            end
            default: state_ff <= ST_LOAD;
         endcase
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.quantity_index = rsp_idx_ff;
   assign rsp.quantity_value = rsp_val_ff;
   assign rsp.last_quantity  = rsp_last_ff;

   // ---------------- checks ----------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_PARTICLES))
      else $error("kept count above store depth");

   a_done_pending: assert property (@(posedge clock) disable iff (reset)
      alu_rsp.done |-> pend_ff)
      else $error("unit result with no command pending");

   a_last_starts: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && req.last_particle) |=> (state_ff == ST_INIT))
      else $error("closing item did not start the final pass");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_idx_ff == RES_LAST))
      else $error("last flag on wrong quantity");

endmodule
`default_nettype wire

### src/bpsm_alu.sv
`default_nettype none
// shared iterative unit: shift-add multiply, restoring divide with rounding,
// digit-by-digit square root
module bpsm_alu import bpsm_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire alu_cmd_type cmd,
   output alu_rsp_type      rsp
);

   typedef enum logic [5:0] {
      U_IDLE  = 6'b000001,
      U_MUL   = 6'b000010,
      U_DPREP = 6'b000100,
      U_DIV   = 6'b001000,
      U_SQRT  = 6'b010000,
      U_FIN   = 6'b100000
   } ustate_type;

   ustate_type             ustate_ff, ustate_in;
   alu_op_type             op_ff, op_in;
   logic [WIDE_W-1:0]      acc_ff, acc_in;
   logic [WIDE_W-1:0]      opa_ff, opa_in;
   logic [63:0]            opb_ff, opb_in;
   logic [WIDE_W:0]        rem_ff, rem_in;
   logic                   neg_ff, neg_in;
   logic [8:0]             iter_ff, iter_in;
   logic signed [WIDE_W-1:0] res_ff, res_in;
   logic                   done_ff, done_in;

   logic [WIDE_W:0]        div_sh;
   logic [67:0]            sq_sh;
   logic [67:0]            sq_trial;
   logic [WIDE_W-1:0]      abs_a;
   logic [WIDE_W-1:0]      abs_b;
   logic [63:0]            abs_b64;

   assign abs_a   = cmd.a[WIDE_W-1] ? WIDE_W'(-cmd.a) : cmd.a;
   assign abs_b   = cmd.b[WIDE_W-1] ? WIDE_W'(-cmd.b) : cmd.b;
   assign abs_b64 = cmd.b[63] ? 64'(-cmd.b[63:0]) : cmd.b[63:0];
   assign div_sh  = {rem_ff[WIDE_W-1:0], acc_ff[WIDE_W-1]};
   assign sq_sh   = {rem_ff[65:0], acc_ff[WIDE_W-1:WIDE_W-2]};
   assign sq_trial = {2'b00, opb_ff, 2'b01};

   always_comb begin
      ustate_in = ustate_ff;
      op_in     = op_ff;
      acc_in    = acc_ff;
      opa_in    = opa_ff;
      opb_in    = opb_ff;
      rem_in    = rem_ff;
      neg_in    = neg_ff;
      iter_in   = iter_ff;
      res_in    = res_ff;
      done_in   = 1'b0;
      case (ustate_ff)
         U_IDLE: begin
            if (cmd.start) begin
               op_in = cmd.op;
               case (cmd.op)
                  ALU_MUL: begin
                     acc_in    = '0;
                     opa_in    = abs_a;
                     opb_in    = abs_b64;
                     neg_in    = cmd.a[WIDE_W-1] ^ cmd.b[63];
                     ustate_in = U_MUL;
                  end
                  ALU_DIV: begin
                     acc_in    = abs_a;
                     opa_in    = abs_b;
                     neg_in    = cmd.a[WIDE_W-1] ^ cmd.b[WIDE_W-1];
                     ustate_in = U_DPREP;
                  end
                  default: begin
                     acc_in    = {cmd.a[127:0], 128'd0};
                     opb_in    = '0;
                     rem_in    = '0;
                     neg_in    = 1'b0;
                     iter_in   = 9'd64;
                     ustate_in = U_SQRT;
                  end
               endcase
            end
         end
         U_MUL: begin
            if (opb_ff == '0) begin
               ustate_in = U_FIN;
            end else begin
               if (opb_ff[0]) acc_in = acc_ff + opa_ff;
               opa_in = {opa_ff[WIDE_W-2:0], 1'b0};
               opb_in = {1'b0, opb_ff[63:1]};
            end
         end
         U_DPREP: begin
            // round to nearest: (2|n| + |d|) / (2|d|)
            acc_in    = {acc_ff[WIDE_W-2:0], 1'b0} + opa_ff;
            opa_in    = {opa_ff[WIDE_W-2:0], 1'b0};
            rem_in    = '0;
            iter_in   = 9'(WIDE_W);
            ustate_in = U_DIV;
         end
         U_DIV: begin
            if (div_sh >= {1'b0, opa_ff}) begin
               rem_in = div_sh - {1'b0, opa_ff};
               acc_in = {acc_ff[WIDE_W-2:0], 1'b1};
            end else begin
               rem_in = div_sh;
               acc_in = {acc_ff[WIDE_W-2:0], 1'b0};
            end
            iter_in = iter_ff - 9'd1;
            if (iter_ff == 9'd1) ustate_in = U_FIN;
         end
         U_SQRT: begin
            if (sq_sh >= sq_trial) begin
               rem_in = (WIDE_W+1)'(sq_sh - sq_trial);
               opb_in = {opb_ff[62:0], 1'b1};
            end else begin
               rem_in = (WIDE_W+1)'(sq_sh);
               opb_in = {opb_ff[62:0], 1'b0};
            end
            acc_in  = {acc_ff[WIDE_W-3:0], 2'b00};
            iter_in = iter_ff - 9'd1;
            if (iter_ff == 9'd1) ustate_in = U_FIN;
         end
         U_FIN: begin
            if (op_ff == ALU_SQRT) begin
               res_in = {{(WIDE_W-64){1'b0}}, opb_ff};
            end else begin
               res_in = neg_ff ? WIDE_W'(-acc_ff) : acc_ff;
            end
            done_in   = 1'b1;
            ustate_in = U_IDLE;
         end
         default: ustate_in = U_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ustate_ff <= U_IDLE;
         done_ff   <= 1'b0;
      end else begin
         ustate_ff <= ustate_in;
         done_ff   <= done_in;
      end
      op_ff   <= op_in;
      acc_ff  <= acc_in;
      opa_ff  <= opa_in;
      opb_ff  <= opb_in;
      rem_ff  <= rem_in;
      neg_ff  <= neg_in;
      iter_ff <= iter_in;
      res_ff  <= res_in;
   end

   assign rsp.done = done_ff;
   assign rsp.res  = res_ff;

endmodule
`default_nettype wire
